// ===== src/hvd_pkg.sv =====
// Shared constants for the haversine distance pipeline.
// Holds the CORDIC arctangent table, fixed-point constants and stage widths.
// No dependencies.
package hvd_pkg;

   localparam int CORDIC_STEPS = 31;
   localparam int ISQRT_STEPS = 31;
   localparam int DIV_NUM_W = 38;

   // Rotation start value: inverse CORDIC gain in Q30
   localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;

   localparam logic [30:0] ONE_Q30 = 31'd1073741824;
   localparam logic [32:0] RECIP_45 = 33'd6108397932;
   localparam logic [30:0] DIST_SCALE = 31'd1311708728;

   // Arctangent of 2^-i in binary angle units, one turn = 2^32
   localparam logic [29:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
      30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
      30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
      30'd20, 30'd10, 30'd5, 30'd3, 30'd1,
      30'd1
   };

endpackage

// ===== src/hvd_div45.sv =====
// Degree-to-turn conversion: floor(num / 45) by reciprocal multiply.
// Three register stages: partial products, sum, correction and sign.
// Depends on hvd_pkg.
module hvd_div45 import hvd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [DIV_NUM_W-1:0] in_num,
   input  logic                 in_neg,
   output logic                 out_valid,
   output logic [31:0]          out_turn
);

   logic        vld1_ff, vld2_ff, vld3_ff;
   logic [51:0] pp_hi_ff, pp_lo_ff;
   logic [7:0]  num_lo1_ff, num_lo2_ff;
   logic        neg1_ff, neg2_ff;
   logic [32:0] qest_ff;
   logic [31:0] turn_ff;

   logic [70:0] sum_in;
   logic [7:0]  prod45_in;
   logic [7:0]  rem_in;
   logic [31:0] quot_in;
   logic [31:0] turn_in;

   assign sum_in = {pp_hi_ff, 19'b0} + {19'b0, pp_lo_ff};

   // The estimate is low by at most one; the true remainder stays below 90
   always_comb begin
      prod45_in = 8'(qest_ff[7:0] * 8'd45);
      rem_in = num_lo2_ff - prod45_in;
      quot_in = qest_ff[31:0] + ((rem_in >= 8'd45) ? 32'd1 : 32'd0);
      turn_in = neg2_ff ? (32'd0 - quot_in) : quot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (advance) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
      if (advance) begin
         pp_hi_ff <= 52'(in_num[37:19]) * 52'(RECIP_45);
         pp_lo_ff <= 52'(in_num[18:0]) * 52'(RECIP_45);
         num_lo1_ff <= in_num[7:0];
         neg1_ff <= in_neg;
         qest_ff <= sum_in[70:38];
         num_lo2_ff <= num_lo1_ff;
         neg2_ff <= neg1_ff;
         turn_ff <= turn_in;
      end
   end

   assign out_valid = vld3_ff;
   assign out_turn = turn_ff;

endmodule

// ===== src/hvd_rot_cordic.sv =====
// Pipelined rotation CORDIC: sine and cosine of a binary angle in Q30.
// Quadrant fold stage, one stage per micro-rotation, then negate and clamp.
// Depends on hvd_pkg.
module hvd_rot_cordic import hvd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [31:0]        in_turn,
   output logic               out_valid,
   output logic signed [31:0] sin_q30,
   output logic signed [31:0] cos_q30
);

   localparam logic signed [33:0] POS_ONE = 34'sd1073741824;
   localparam logic signed [33:0] NEG_ONE = -34'sd1073741824;

   logic               vld_ff  [0:CORDIC_STEPS];
   logic               flip_ff [0:CORDIC_STEPS];
   logic signed [33:0] x_ff    [0:CORDIC_STEPS];
   logic signed [33:0] y_ff    [0:CORDIC_STEPS];
   logic signed [33:0] z_ff    [0:CORDIC_STEPS];

   logic               out_vld_ff;
   logic signed [31:0] sin_ff, cos_ff;

   logic [31:0]        shifted_in;
   logic               flip_in;
   logic [31:0]        folded_in;
   logic signed [33:0] xn_in, yn_in;
   logic signed [31:0] sin_in, cos_in;

   // Fold the angle into [-1/4, 1/4) turn
   always_comb begin
      shifted_in = in_turn + 32'h4000_0000;
      flip_in = shifted_in[31];
      folded_in = flip_in ? (in_turn + 32'h8000_0000) : in_turn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
      end
      if (advance) begin
         flip_ff[0] <= flip_in;
         x_ff[0] <= CORDIC_GAIN_INV;
         y_ff[0] <= '0;
         z_ff[0] <= $signed({{2{folded_in[31]}}, folded_in});
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [33:0] atan_ext;
      logic signed [33:0] x_in, y_in, z_in;

      assign atan_ext = $signed({4'b0, ATAN_TURNS[i]});

      always_comb begin
         if (!z_ff[i][33]) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - atan_ext;
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + atan_ext;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (advance) begin
            flip_ff[i+1] <= flip_ff[i];
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
         end
      end
   end

   // Undo the fold, then clamp to [-1, 1]
   always_comb begin
      xn_in = flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
      yn_in = flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
      if (xn_in > POS_ONE) begin
         cos_in = POS_ONE[31:0];
      end else if (xn_in < NEG_ONE) begin
         cos_in = NEG_ONE[31:0];
      end else begin
         cos_in = xn_in[31:0];
      end
      if (yn_in > POS_ONE) begin
         sin_in = POS_ONE[31:0];
      end else if (yn_in < NEG_ONE) begin
         sin_in = NEG_ONE[31:0];
      end else begin
         sin_in = yn_in[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= vld_ff[CORDIC_STEPS];
      end
      if (advance) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign sin_q30 = sin_ff;
   assign cos_q30 = cos_ff;

endmodule

// ===== src/hvd_isqrt.sv =====
// Pipelined floor square root of a Q60 value, giving Q30.
// Load stage, then one stage per result bit (restoring digit recurrence).
// Depends on hvd_pkg.
module hvd_isqrt import hvd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  logic [60:0] in_value,
   output logic        out_valid,
   output logic [30:0] out_root
);

   logic        vld_ff  [0:ISQRT_STEPS];
   logic [61:0] rem_ff  [0:ISQRT_STEPS];
   logic [61:0] root_ff [0:ISQRT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
      end
      if (advance) begin
         rem_ff[0] <= {1'b0, in_value};
         root_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_step
      localparam logic [61:0] TRIAL_BIT = 62'd1 << (60 - 2 * k);
      logic [61:0] trial_in;
      logic [61:0] rem_in, root_in;

      always_comb begin
         trial_in = root_ff[k] + TRIAL_BIT;
         if (rem_ff[k] >= trial_in) begin
            rem_in = rem_ff[k] - trial_in;
            root_in = (root_ff[k] >> 1) + TRIAL_BIT;
         end else begin
            rem_in = rem_ff[k];
            root_in = root_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (advance) begin
            rem_ff[k+1] <= rem_in;
            root_ff[k+1] <= root_in;
         end
      end
   end

   assign out_valid = vld_ff[ISQRT_STEPS];
   assign out_root = root_ff[ISQRT_STEPS][30:0];

endmodule

// ===== src/hvd_vec_cordic.sv =====
// Pipelined vectoring CORDIC: angle of (x, y) in binary angle units.
// Load stage, one stage per micro-rotation, then a clamp to [0, 1/4 turn].
// Depends on hvd_pkg.
module hvd_vec_cordic import hvd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  logic [30:0] in_x,
   input  logic [30:0] in_y,
   output logic        out_valid,
   output logic [30:0] out_angle
);

   logic               vld_ff [0:CORDIC_STEPS];
   logic signed [34:0] x_ff   [0:CORDIC_STEPS];
   logic signed [34:0] y_ff   [0:CORDIC_STEPS];
   logic signed [32:0] z_ff   [0:CORDIC_STEPS];

   logic        out_vld_ff;
   logic [30:0] angle_ff;
   logic [30:0] angle_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
      end
      if (advance) begin
         x_ff[0] <= $signed({4'b0, in_x});
         y_ff[0] <= $signed({4'b0, in_y});
         z_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [32:0] atan_ext;
      logic signed [34:0] x_in, y_in;
      logic signed [32:0] z_in;

      assign atan_ext = $signed({3'b0, ATAN_TURNS[i]});

      // Rotate toward the x axis
      always_comb begin
         if (!y_ff[i][34]) begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + atan_ext;
         end else begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - atan_ext;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (advance) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
         end
      end
   end

   always_comb begin
      if (z_ff[CORDIC_STEPS][32]) begin
         angle_in = '0;
      end else if (z_ff[CORDIC_STEPS] > $signed({2'b0, ONE_Q30})) begin
         angle_in = ONE_Q30;
      end else begin
         angle_in = z_ff[CORDIC_STEPS][30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= vld_ff[CORDIC_STEPS];
      end
      if (advance) begin
         angle_ff <= angle_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_angle = angle_ff;

endmodule

// ===== src/haversine_distance_top.sv =====
// Haversine great-circle distance, fully pipelined.
// Throughput one beat per cycle, unless a finished result is held by rsp_stall.
// Depth is set by the two 33-stage CORDIC chains and the 32-stage square root.
// A stalled result freezes the whole pipeline; bubbles are kept, never merged.
// Synchronous reset clears only the valid bits; data registers are not reset.
module haversine_distance_top import hvd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [27:0] req_lat_a,
   input  logic signed [28:0] req_lon_a,
   input  logic signed [27:0] req_lat_b,
   input  logic signed [28:0] req_lon_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [22:0]        rsp_distance_km
);

   logic advance;

   // Input preparation stage
   logic signed [28:0] dlat_in;
   logic signed [29:0] dlon_in;
   logic [28:0]        dlat_abs_in;
   logic [29:0]        dlon_abs_in;
   logic [27:0]        lata_abs_in, latb_abs_in;
   logic               prep_vld_ff;
   logic [DIV_NUM_W-1:0] num_dlat_ff, num_dlon_ff, num_lata_ff, num_latb_ff;
   logic               neg_dlat_ff, neg_dlon_ff, neg_lata_ff, neg_latb_ff;

   logic        turn_vld;
   logic [31:0] turn_dlat, turn_dlon, turn_lata, turn_latb;

   logic               trig_vld;
   logic signed [31:0] sin_dlat, sin_dlon, cos_lata, cos_latb;

   // Haversine combine stages
   logic [30:0]        mag_dlat_in, mag_dlon_in;
   logic               m1_vld_ff, m2_vld_ff, m3_vld_ff, m4_vld_ff;
   logic signed [63:0] cc_ff;
   logic [60:0]        sq_dlat_ff, sq_dlon_ff;
   logic signed [63:0] cc_rnd_in;
   logic [60:0]        sq_dlat_rnd_in, sq_dlon_rnd_in;
   logic signed [31:0] p_ff;
   logic [30:0]        hs_dlat_ff, hs_dlon_ff, hs_dlat_d_ff;
   logic signed [63:0] t_ff;
   logic signed [63:0] t_rnd_in;
   logic signed [32:0] a_raw_in;
   logic [30:0]        a_in;
   logic [30:0]        a_ff;
   logic [30:0]        a_comp_in;

   logic        root_vld;
   logic [30:0] root_y, root_x;

   logic        angle_vld;
   logic [30:0] angle;

   logic        d1_vld_ff, out_vld_ff;
   logic [61:0] dist_prod_ff;
   logic [61:0] dist_rnd_in;
   logic [22:0] dist_ff;

   // Advance the whole pipe unless a finished result is held
   assign advance = !(out_vld_ff && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      dlat_in = $signed({req_lat_b[27], req_lat_b}) - $signed({req_lat_a[27], req_lat_a});
      dlon_in = $signed({req_lon_b[28], req_lon_b}) - $signed({req_lon_a[28], req_lon_a});
      dlat_abs_in = dlat_in[28] ? 29'(-dlat_in) : 29'(dlat_in);
      dlon_abs_in = dlon_in[29] ? 30'(-dlon_in) : 30'(dlon_in);
      lata_abs_in = req_lat_a[27] ? 28'(-req_lat_a) : 28'(req_lat_a);
      latb_abs_in = req_lat_b[27] ? 28'(-req_lat_b) : 28'(req_lat_b);
   end

   // Half differences scale by 256/45, latitudes by 512/45; +22 rounds half away
   always_ff @(posedge clock) begin
      if (reset) begin
         prep_vld_ff <= 1'b0;
      end else if (advance) begin
         prep_vld_ff <= req_valid;
      end
      if (advance) begin
         num_dlat_ff <= {1'b0, dlat_abs_in, 8'b0} + 38'd22;
         num_dlon_ff <= {dlon_abs_in, 8'b0} + 38'd22;
         num_lata_ff <= {1'b0, lata_abs_in, 9'b0} + 38'd22;
         num_latb_ff <= {1'b0, latb_abs_in, 9'b0} + 38'd22;
         neg_dlat_ff <= dlat_in[28];
         neg_dlon_ff <= dlon_in[29];
         neg_lata_ff <= req_lat_a[27];
         neg_latb_ff <= req_lat_b[27];
      end
   end

   hvd_div45 u_div_dlat (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(prep_vld_ff),
      .in_num(num_dlat_ff), .in_neg(neg_dlat_ff),
      .out_valid(turn_vld), .out_turn(turn_dlat)
   );
   hvd_div45 u_div_dlon (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(prep_vld_ff),
      .in_num(num_dlon_ff), .in_neg(neg_dlon_ff),
      .out_valid(), .out_turn(turn_dlon)
   );
   hvd_div45 u_div_lata (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(prep_vld_ff),
      .in_num(num_lata_ff), .in_neg(neg_lata_ff),
      .out_valid(), .out_turn(turn_lata)
   );
   hvd_div45 u_div_latb (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(prep_vld_ff),
      .in_num(num_latb_ff), .in_neg(neg_latb_ff),
      .out_valid(), .out_turn(turn_latb)
   );

   hvd_rot_cordic u_rot_dlat (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(turn_vld),
      .in_turn(turn_dlat), .out_valid(trig_vld), .sin_q30(sin_dlat), .cos_q30()
   );
   hvd_rot_cordic u_rot_dlon (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(turn_vld),
      .in_turn(turn_dlon), .out_valid(), .sin_q30(sin_dlon), .cos_q30()
   );
   hvd_rot_cordic u_rot_lata (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(turn_vld),
      .in_turn(turn_lata), .out_valid(), .sin_q30(), .cos_q30(cos_lata)
   );
   hvd_rot_cordic u_rot_latb (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(turn_vld),
      .in_turn(turn_latb), .out_valid(), .sin_q30(), .cos_q30(cos_latb)
   );

   always_comb begin
      mag_dlat_in = sin_dlat[31] ? 31'(-sin_dlat) : 31'(sin_dlat);
      mag_dlon_in = sin_dlon[31] ? 31'(-sin_dlon) : 31'(sin_dlon);
      cc_rnd_in = cc_ff + 64'sd536870912;
      sq_dlat_rnd_in = sq_dlat_ff + 61'd536870912;
      sq_dlon_rnd_in = sq_dlon_ff + 61'd536870912;
      t_rnd_in = t_ff + 64'sd536870912;
      a_raw_in = $signed({2'b00, hs_dlat_d_ff}) + $signed(t_rnd_in[62:30]);
      // Clamp a to [0, 1]
      if (a_raw_in[32]) begin
         a_in = '0;
      end else if (a_raw_in > $signed({2'b00, ONE_Q30})) begin
         a_in = ONE_Q30;
      end else begin
         a_in = a_raw_in[30:0];
      end
      a_comp_in = ONE_Q30 - a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         m3_vld_ff <= 1'b0;
         m4_vld_ff <= 1'b0;
      end else if (advance) begin
         m1_vld_ff <= trig_vld;
         m2_vld_ff <= m1_vld_ff;
         m3_vld_ff <= m2_vld_ff;
         m4_vld_ff <= m3_vld_ff;
      end
      if (advance) begin
         cc_ff <= 64'(cos_lata) * 64'(cos_latb);
         sq_dlat_ff <= 61'(mag_dlat_in) * 61'(mag_dlat_in);
         sq_dlon_ff <= 61'(mag_dlon_in) * 61'(mag_dlon_in);
         p_ff <= cc_rnd_in[61:30];
         hs_dlat_ff <= sq_dlat_rnd_in[60:30];
         hs_dlon_ff <= sq_dlon_rnd_in[60:30];
         t_ff <= 64'(p_ff) * 64'($signed({1'b0, hs_dlon_ff}));
         hs_dlat_d_ff <= hs_dlat_ff;
         a_ff <= a_in;
      end
   end

   hvd_isqrt u_sqrt_a (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(m4_vld_ff),
      .in_value({a_ff, 30'b0}), .out_valid(root_vld), .out_root(root_y)
   );
   hvd_isqrt u_sqrt_comp (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(m4_vld_ff),
      .in_value({a_comp_in, 30'b0}), .out_valid(), .out_root(root_x)
   );

   hvd_vec_cordic u_vec (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(root_vld),
      .in_x(root_x), .in_y(root_y), .out_valid(angle_vld), .out_angle(angle)
   );

   assign dist_rnd_in = dist_prod_ff + (62'd1 << 37);

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         d1_vld_ff <= angle_vld;
         out_vld_ff <= d1_vld_ff;
      end
      if (advance) begin
         dist_prod_ff <= 62'(angle) * 62'(DIST_SCALE);
         dist_ff <= dist_rnd_in[60:38];
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_distance_km = dist_ff;

   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distance_km <= 23'd5123862)
      else $error("distance above half circumference");

   a_hav_clamped: assert property (@(posedge clock) disable iff (reset)
      m4_vld_ff |-> a_ff <= ONE_Q30)
      else $error("haversine term out of range");

   a_roots_bound: assert property (@(posedge clock) disable iff (reset)
      root_vld |-> (root_x <= ONE_Q30) && (root_y <= ONE_Q30))
      else $error("square root above one");

   a_angle_bound: assert property (@(posedge clock) disable iff (reset)
      angle_vld |-> angle <= ONE_Q30)
      else $error("half central angle above quarter turn");

endmodule

// ===== test/haversine_distance_top_tb.sv =====
// Self-checking testbench for haversine_distance_top: fixed-point great-circle distance.
// Predicts each distance with a local fixed-point model of the haversine datapath, unless a directed row types it in.
// Depends on src/hvd_pkg.sv and src/haversine_distance_top.sv.
module haversine_distance_top_tb import hvd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 108;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam longint LAT_MAX = 94371840;
   localparam longint LON_MAX = 188743680;
   localparam longint Q30 = 64'sd1 << 30;
   localparam longint HALFQ = 64'sd1 << 29;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [27:0] req_lat_a = '0;
   logic signed [28:0] req_lon_a = '0;
   logic signed [27:0] req_lat_b = '0;
   logic signed [28:0] req_lon_b = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [22:0] rsp_distance_km;

   haversine_distance_top dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   typedef struct {
      logic signed [27:0] lat_a;
      logic signed [28:0] lon_a;
      logic signed [27:0] lat_b;
      logic signed [28:0] lon_b;
      bit                 known;
      logic [22:0]        want_km;
   } leg_type;

   logic [22:0] pending_dist[$];
   int errors = 0;
   int beats_in = 0;
   int beats_out = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_off = 1'b0;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic [31:0] deg_to_turns(longint d, longint mul);
      longint unsigned m;
      m = d < 0 ? -d : d;
      m = (m * mul + 22) / 45;
      m = m & 64'hFFFF_FFFF;
      if (d < 0) m = (64'd0 - m) & 64'hFFFF_FFFF;
      return m[31:0];
   endfunction

   function automatic void rotate_unit(input logic [31:0] ang, output longint s,
                                       output longint c);
      logic [31:0] u;
      bit flip;
      longint x, y, z, nx;
      u = ang;
      flip = ((u + 32'h4000_0000) >> 30) >= 2;
      if (flip) u = u + 32'h8000_0000;
      z = u[31] ? longint'(u) - (64'sd1 << 32) : longint'(u);
      x = CORDIC_GAIN_INV;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - floor_shr(y, i);
            y = y + floor_shr(x, i);
            z = z - longint'(ATAN_TURNS[i]);
         end else begin
            nx = x + floor_shr(y, i);
            y = y - floor_shr(x, i);
            z = z + longint'(ATAN_TURNS[i]);
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      s = clip(y, -Q30, Q30);
      c = clip(x, -Q30, Q30);
   endfunction

   function automatic longint sq_q30(longint v);
      longint unsigned m;
      m = v < 0 ? -v : v;
      return longint'((m * m + HALFQ) >> 30);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint half_central_angle(longint x, longint y);
      longint z, nx;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (y >= 0) begin
            nx = x + floor_shr(y, i);
            y = y - floor_shr(x, i);
            z = z + longint'(ATAN_TURNS[i]);
         end else begin
            nx = x - floor_shr(y, i);
            y = y + floor_shr(x, i);
            z = z - longint'(ATAN_TURNS[i]);
         end
         x = nx;
      end
      return clip(z, 0, Q30);
   endfunction

   function automatic logic [22:0] predict_distance(longint la, longint oa, longint lb,
                                                    longint ob);
      longint s1, c1, s2, c2, sa, ca, sb, cb, p, hav;
      longint unsigned ys, xs, prod;
      rotate_unit(deg_to_turns(lb - la, 256), s1, c1);
      rotate_unit(deg_to_turns(ob - oa, 256), s2, c2);
      rotate_unit(deg_to_turns(la, 512), sa, ca);
      rotate_unit(deg_to_turns(lb, 512), sb, cb);
      p = floor_shr(ca * cb + HALFQ, 30);
      hav = sq_q30(s1) + floor_shr(p * sq_q30(s2) + HALFQ, 30);
      hav = clip(hav, 0, Q30);
      ys = int_sqrt(longint'(hav) << 30);
      xs = int_sqrt(longint'(Q30 - hav) << 30);
      prod = longint'(half_central_angle(xs, ys)) * longint'(DIST_SCALE) + (64'd1 << 37);
      return prod[60:38];
   endfunction

   // Directed rows; expected distance typed in only where it is obvious.
   leg_type directed[] = '{
      '{28'sd0, 29'sd0, 28'sd0, 29'sd0, 1'b1, 23'd0},
      '{28'sd94371840, 29'sd188743680, 28'sd94371840, 29'sd188743680, 1'b1, 23'd0},
      '{-28'sd94371840, -29'sd188743680, -28'sd94371840, -29'sd188743680, 1'b1, 23'd0},
      '{28'sd0, 29'sd0, 28'sd0, 29'sd188743680, 1'b0, 23'd0},
      '{28'sd94371840, 29'sd0, -28'sd94371840, 29'sd0, 1'b0, 23'd0},
      '{28'sd0, -29'sd188743680, 28'sd0, 29'sd188743680, 1'b0, 23'd0},
      '{28'sd94371840, -29'sd188743680, -28'sd94371840, 29'sd188743680, 1'b0, 23'd0},
      '{28'sd0, 29'sd0, 28'sd1, 29'sd0, 1'b0, 23'd0},
      '{28'sd0, 29'sd0, 28'sd0, -29'sd1, 1'b0, 23'd0},
      '{28'sd47185920, 29'sd94371840, -28'sd47185920, -29'sd94371840, 1'b0, 23'd0},
      '{28'h7FF_FFFF, 29'h0FFF_FFFF, 28'h800_0000, 29'h1000_0000, 1'b0, 23'd0},
      '{28'h800_0000, 29'h1000_0000, 28'h7FF_FFFF, 29'h0FFF_FFFF, 1'b0, 23'd0},
      '{28'h7FF_FFFF, 29'h1000_0000, 28'h7FF_FFFF, 29'h1000_0000, 1'b0, 23'd0},
      '{28'sd90000000, 29'sd100000000, 28'sd89000000, 29'sd100000001, 1'b0, 23'd0},
      '{28'sd94371839, 29'sd0, 28'sd94371840, 29'sd188743679, 1'b0, 23'd0},
      '{-28'sd50000000, 29'sd12345678, 28'sd40000000, -29'sd150000000, 1'b0, 23'd0},
      '{28'h555_5555, 29'h0AAA_AAAA, 28'h2AA_AAAA, 29'h1555_5555, 1'b0, 23'd0}
   };

   task automatic send_beat(input logic signed [27:0] la, input logic signed [28:0] oa,
                            input logic signed [27:0] lb, input logic signed [28:0] ob,
                            input bit known, input logic [22:0] fixed_dist);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_lat_a <= la;
      req_lon_a <= oa;
      req_lat_b <= lb;
      req_lon_b <= ob;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_dist.push_back(known ? fixed_dist : predict_distance(la, oa, lb, ob));
      beats_in++;
   endtask

   function automatic logic signed [27:0] pick_lat();
      case ($urandom_range(9))
         0: return 28'($urandom);
         1: return $urandom_range(1) ? 28'(LAT_MAX) : 28'(-LAT_MAX);
         default: return 28'(longint'($urandom_range(32'(2 * LAT_MAX))) - LAT_MAX);
      endcase
   endfunction

   function automatic logic signed [28:0] pick_lon();
      case ($urandom_range(9))
         0: return 29'($urandom);
         1: return $urandom_range(1) ? 29'(LON_MAX) : 29'(-LON_MAX);
         default: return 29'(longint'($urandom_range(32'(2 * LON_MAX))) - LON_MAX);
      endcase
   endfunction

   task automatic random_phase(input int count, input int idle_pct, input int stall_in);
      logic signed [27:0] la, lb;
      logic signed [28:0] oa, ob;
      send_idle_pct = idle_pct;
      stall_pct = stall_in;
      for (int n = 0; n < count; n++) begin
         la = pick_lat();
         oa = pick_lon();
         // Mix in near-coincident and near-antipodal pairs.
         case ($urandom_range(5))
            0: begin
               lb = 28'(la + $signed(28'($urandom_range(64))) - 32);
               ob = 29'(oa + $signed(29'($urandom_range(64))) - 32);
            end
            1: begin
               lb = -la;
               ob = 29'(oa + (oa < 0 ? LON_MAX : -LON_MAX)
                        + $signed(29'($urandom_range(8))) - 4);
            end
            default: begin
               lb = pick_lat();
               ob = pick_lon();
            end
         endcase
         send_beat(la, oa, lb, ob, 1'b0, '0);
      end
      req_valid <= 1'b0;
   endtask

   // Result side: stall at random, or hold off entirely while hold_off is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_out++;
         if (pending_dist.size() == 0) begin
            $error("unexpected beat: distance_km actual %0d", rsp_distance_km);
            errors++;
         end else begin
            logic [22:0] want;
            want = pending_dist.pop_front();
            if (rsp_distance_km !== want) begin
               $error("distance_km mismatch: expected %0d, actual %0d", want,
                      rsp_distance_km);
               errors++;
            end
         end
      end
   end

   // Watchdog: count cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_dist.size());
            $display("haversine_distance_top_tb NOT OK");
            $finish;
         end
      end
   end

   task automatic drain();
      while (pending_dist.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k])
         send_beat(directed[k].lat_a, directed[k].lon_a, directed[k].lat_b,
                   directed[k].lon_b, directed[k].known, directed[k].want_km);
      req_valid <= 1'b0;
      drain();

      random_phase(200, 0, 0);
      random_phase(150, 77, 0);
      random_phase(150, 0, 77);
      random_phase(150, 29, 29);

      // Hold the result side off long enough to back the pipeline up.
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         random_phase(150, 0, 0);
      join
      drain();
      repeat (LATENCY + 20) @(posedge clock);

      $display("covered %0d beats in, %0d out: directed extremes, antipodes, wraps,",
               beats_in, beats_out);
      $display("random pairs under idle, stall and long back-pressure phases");
      if (errors == 0 && pending_dist.size() == 0) begin
         $display("haversine_distance_top_tb OK");
      end else begin
         $display("haversine_distance_top_tb NOT OK");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
src/hvd_pkg.sv
src/hvd_div45.sv
src/hvd_rot_cordic.sv
src/hvd_isqrt.sv
src/hvd_vec_cordic.sv
src/haversine_distance_top.sv
test/haversine_distance_top_tb.sv
